[rtl/core/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator package
// Shared types, register map and fixed-point constants for the generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_BITS        = 16;

    localparam int TIME_W   = 32;
    localparam int FREQ_W   = 24;
    localparam int AMP_W    = 24;
    localparam int RECIP_W  = 49;
    localparam int ENV_W    = 17;
    localparam int SAMPLE_W = 24;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [ENV_W-1:0] ENV_ONE = 17'd65536;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 49'h1_0000_0000_0000;

    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                               64'd42, 64'd20, 64'd6};

    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_FREQUENCY    = 3'd1,
        REG_AMPLITUDE    = 3'd2,
        REG_TAPER_LENGTH = 3'd3,
        REG_TAPER_RECIP  = 3'd4,
        REG_DURATION     = 3'd5
    } tsg_reg_t;

    typedef enum logic [1:0] {
        ENV_UNITY = 2'd0,
        ENV_ZERO  = 2'd1,
        ENV_RAMP  = 2'd2
    } tsg_env_sel_t;

    typedef struct packed {
        logic                     mode;
        logic [FREQ_W-1:0]        frequency;
        logic signed [AMP_W-1:0]  amplitude;
        logic [TIME_W-1:0]        taper_length;
        logic [RECIP_W-1:0]       taper_reciprocal;
        logic [TIME_W-1:0]        duration;
    } tsg_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic [TIME_W-1:0] distance;
        tsg_env_sel_t      env_sel;
    } tsg_item_t;

endpackage

[rtl/core/tapered_sine_generator_core.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator core
// Turns time beats into sine samples shaped by an optional linear taper.
// ----------------------------------------------------------------------------
// The core takes one time beat per clock and returns one sample per clock in
// steady state while the output is not stalled. A beat accepted into an empty
// core is written into the four-entry input queue and then passes through the
// six-stage datapath of phase and envelope products, table address, registered
// sine table read, two scaling multiplications and the rounding and clamping
// output register. The input side keeps accepting beats while the output is
// stalled until the queue is full. Configuration is to be written over the APB
// port only while the core is idle; the core itself does not enforce this.
module tapered_sine_generator_core #(
    parameter int SINE_TABLE_DEPTH = tsg_pkg::SINE_TABLE_DEPTH,
    parameter int SINE_BITS        = tsg_pkg::SINE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tsg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tsg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tsg_pkg::TIME_W-1:0]         time_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tsg_pkg::SAMPLE_W-1:0]       sample
);

    tsg_pkg::tsg_cfg_t  cfg;
    tsg_pkg::tsg_item_t push_item;
    tsg_pkg::tsg_item_t head_item;
    logic               push;
    logic               queue_full;
    logic               pop;
    logic               head_valid;

    tsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsg_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .time_value (time_value),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    tsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tsg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SINE_BITS        (SINE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample)
    );

endmodule

[rtl/core/tsg_regs.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator configuration registers
// APB-style register file holding mode, frequency, amplitude, duration and taper setup.
// ----------------------------------------------------------------------------
module tsg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tsg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tsg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output tsg_pkg::tsg_cfg_t                  cfg
);

    tsg_pkg::tsg_cfg_t cfg_reg;
    tsg_pkg::tsg_cfg_t cfg_next;
    logic [2:0]        reg_index;
    logic              write_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign write_en  = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (reg_index)
                tsg_pkg::REG_MODE:         cfg_next.mode = pwdata[0];
                tsg_pkg::REG_FREQUENCY:    cfg_next.frequency = pwdata[23:0];
                tsg_pkg::REG_AMPLITUDE:    cfg_next.amplitude = pwdata[23:0];
                tsg_pkg::REG_TAPER_LENGTH: cfg_next.taper_length = pwdata[31:0];
                tsg_pkg::REG_TAPER_RECIP:  cfg_next.taper_reciprocal = pwdata[48:0];
                tsg_pkg::REG_DURATION:     cfg_next.duration = pwdata[31:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            tsg_pkg::REG_MODE:         prdata = 64'(cfg_reg.mode);
            tsg_pkg::REG_FREQUENCY:    prdata = 64'(cfg_reg.frequency);
            tsg_pkg::REG_AMPLITUDE:    prdata = 64'(unsigned'(cfg_reg.amplitude));
            tsg_pkg::REG_TAPER_LENGTH: prdata = 64'(cfg_reg.taper_length);
            tsg_pkg::REG_TAPER_RECIP:  prdata = 64'(cfg_reg.taper_reciprocal);
            tsg_pkg::REG_DURATION:     prdata = 64'(cfg_reg.duration);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= 1'b0;
            cfg_reg.frequency        <= '0;
            cfg_reg.amplitude        <= '0;
            cfg_reg.taper_length     <= 32'd1;
            cfg_reg.taper_reciprocal <= tsg_pkg::RECIP_RESET;
            cfg_reg.duration         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/tsg_front.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator front end
// Accepts time beats and classifies each one against the taper envelope rules.
// ----------------------------------------------------------------------------
module tsg_front (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tsg_pkg::TIME_W-1:0]        time_value,
    input  tsg_pkg::tsg_cfg_t                 cfg,
    input  logic                              queue_full,
    output logic                              push,
    output tsg_pkg::tsg_item_t                item
);

    logic [tsg_pkg::TIME_W-1:0] end_distance;
    logic                       in_start_ramp;
    logic                       in_end_ramp;
    logic                       past_end;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign end_distance  = cfg.duration - time_value;
    assign in_start_ramp = time_value < cfg.taper_length;
    assign in_end_ramp   = (time_value <= cfg.duration) && (end_distance < cfg.taper_length);
    assign past_end      = time_value > cfg.duration;

    always_comb
    begin
        item.time_value = time_value;
        item.distance   = time_value;
        item.env_sel    = tsg_pkg::ENV_UNITY;
        if (cfg.mode)
        begin
            if (in_start_ramp)
            begin
                item.env_sel = tsg_pkg::ENV_RAMP;
            end
            else if (in_end_ramp)
            begin
                item.distance = end_distance;
                item.env_sel  = tsg_pkg::ENV_RAMP;
            end
            else if (past_end)
            begin
                item.env_sel = tsg_pkg::ENV_ZERO;
            end
        end
    end

endmodule

[rtl/core/tsg_queue.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator item queue
// Short register queue that lets the front end and the datapath stall apart.
// ----------------------------------------------------------------------------
module tsg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tsg_pkg::tsg_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output tsg_pkg::tsg_item_t head_item
);

    localparam int PTR_W = $clog2(tsg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tsg_pkg::QUEUE_DEPTH + 1);

    tsg_pkg::tsg_item_t slot_reg [tsg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign full       = count_reg == CNT_W'(tsg_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/tsg_back.sv]
// ----------------------------------------------------------------------------
// Tapered sine generator datapath
// Pipelined phase, envelope, sine lookup, scaling and clamping of each beat.
// ----------------------------------------------------------------------------
module tsg_back #(
    parameter int SINE_TABLE_DEPTH = tsg_pkg::SINE_TABLE_DEPTH,
    parameter int SINE_BITS        = tsg_pkg::SINE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tsg_pkg::tsg_cfg_t                  cfg,
    input  logic                               head_valid,
    input  tsg_pkg::tsg_item_t                 head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tsg_pkg::SAMPLE_W-1:0]       sample
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TIME_W  = tsg_pkg::TIME_W;
    localparam int ENV_W   = tsg_pkg::ENV_W;
    localparam int AMP_W   = tsg_pkg::AMP_W;
    localparam int M1_W    = AMP_W + SINE_BITS - 1;
    localparam int M2_W    = M1_W + ENV_W;
    localparam int SHIFT   = SINE_BITS - 1 + 16;
    localparam int RES_W   = M2_W - SHIFT;
    localparam int HI_W    = tsg_pkg::RECIP_W - 32;
    localparam int PHI_W   = TIME_W + HI_W;

    function automatic logic [63:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] peak;
        peak = (64'd1 << (SINE_BITS - 1)) - 64'd1;
        x    = (tsg_pkg::PI_HALF_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        t    = tsg_pkg::Q30_ONE;
        for (int n = 0; n < 6; n++)
        begin
            t = tsg_pkg::Q30_ONE - ((x2 * t) >> 30) / tsg_pkg::TAYLOR_DIV[n];
        end
        s = (x * t) >> 30;
        v = (s * peak + (64'd1 << 29)) >> 30;
        if (v > peak)
        begin
            v = peak;
        end
        return v;
    endfunction

    logic [SINE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = SINE_BITS'(sine_entry(k));
    end

    logic advance;

    // Stage 1: phase and envelope products.
    logic                       v1_reg;
    logic [31:0]                phase1_reg;
    logic [31:0]                phase1_next;
    tsg_pkg::tsg_env_sel_t      sel1_reg;
    logic [31:0]                plo1_reg;
    logic [63:0]                plo1_next;
    logic [PHI_W-1:0]           phi1_reg;
    logic [PHI_W-1:0]           phi1_next;

    // Stage 2: table address and envelope.
    logic                       v2_reg;
    logic [IDX_W-1:0]           addr2_reg;
    logic [IDX_W-1:0]           addr2_next;
    logic                       neg2_reg;
    logic [ENV_W-1:0]           env2_reg;
    logic [ENV_W-1:0]           env2_next;
    logic [63:0]                idx_wide;
    logic [IDX_W-1:0]           idx;
    logic [PHI_W:0]             ramp_sum;

    // Stage 3: table read.
    logic                       v3_reg;
    logic [SINE_BITS-1:0]       smag3_reg;
    logic                       neg3_reg;
    logic [ENV_W-1:0]           env3_reg;

    // Stage 4: amplitude times sine.
    logic                       v4_reg;
    logic [M1_W-1:0]            m1_reg;
    logic [M1_W-1:0]            m1_next;
    logic                       neg4_reg;
    logic [ENV_W-1:0]           env4_reg;
    logic [AMP_W-1:0]           amag;

    // Stage 5: times envelope.
    logic                       v5_reg;
    logic [M2_W-1:0]            m2_reg;
    logic [M2_W-1:0]            m2_next;
    logic                       neg5_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [tsg_pkg::SAMPLE_W-1:0] sample_reg;
    logic [tsg_pkg::SAMPLE_W-1:0] sample_next;
    logic [M2_W-1:0]            rounded;
    logic [RES_W-1:0]           mag;

    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && head_valid;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_comb
    begin
        phase1_next = 32'(64'(head_item.time_value) * 64'(cfg.frequency));
        plo1_next   = 64'(head_item.distance) * 64'(cfg.taper_reciprocal[31:0]);
        phi1_next   = PHI_W'(head_item.distance) *
                      PHI_W'(cfg.taper_reciprocal[tsg_pkg::RECIP_W-1:32]);
    end

    always_comb
    begin
        idx_wide = (64'(phase1_reg[29:0]) * 64'(SINE_TABLE_DEPTH)) >> 30;
        idx      = idx_wide[IDX_W-1:0];
        if (phase1_reg[30])
        begin
            addr2_next = IDX_W'(SINE_TABLE_DEPTH) - idx;
        end
        else
        begin
            addr2_next = idx;
        end
        ramp_sum = (PHI_W + 1)'(phi1_reg) + (PHI_W + 1)'(plo1_reg);
        case (sel1_reg)
            tsg_pkg::ENV_ZERO: env2_next = '0;
            tsg_pkg::ENV_RAMP:
            begin
                if (ramp_sum > (PHI_W + 1)'(tsg_pkg::ENV_ONE))
                begin
                    env2_next = tsg_pkg::ENV_ONE;
                end
                else
                begin
                    env2_next = ramp_sum[ENV_W-1:0];
                end
            end
            default: env2_next = tsg_pkg::ENV_ONE;
        endcase
    end

    always_comb
    begin
        if (cfg.amplitude[AMP_W-1])
        begin
            amag = AMP_W'(-cfg.amplitude);
        end
        else
        begin
            amag = AMP_W'(cfg.amplitude);
        end
        m1_next = M1_W'(amag) * M1_W'(smag3_reg);
        m2_next = M2_W'(m1_reg) * M2_W'(env4_reg);
    end

    always_comb
    begin
        rounded = m2_reg + (M2_W'(1) << (SHIFT - 1));
        mag     = RES_W'(rounded >> SHIFT);
        if (neg5_reg)
        begin
            if (mag > RES_W'(24'd8388608))
            begin
                sample_next = 24'h800000;
            end
            else
            begin
                sample_next = tsg_pkg::SAMPLE_W'(-mag);
            end
        end
        else
        begin
            if (mag > RES_W'(24'd8388607))
            begin
                sample_next = 24'h7FFFFF;
            end
            else
            begin
                sample_next = tsg_pkg::SAMPLE_W'(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= head_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phase1_reg <= phase1_next;
            sel1_reg   <= head_item.env_sel;
            plo1_reg   <= plo1_next[63:32];
            phi1_reg   <= phi1_next;

            addr2_reg  <= addr2_next;
            neg2_reg   <= phase1_reg[31];
            env2_reg   <= env2_next;

            smag3_reg  <= sine_rom[addr2_reg];
            neg3_reg   <= neg2_reg ^ cfg.amplitude[AMP_W-1];
            env3_reg   <= env2_reg;

            m1_reg     <= m1_next;
            neg4_reg   <= neg3_reg;
            env4_reg   <= env3_reg;

            m2_reg     <= m2_next;
            neg5_reg   <= neg4_reg;

            sample_reg <= sample_next;
        end
    end

endmodule
